[src/frame_receiver_with_dedup_ack_unit_macros.svh]
// Assertion macros used by the frx_decode module.
`ifndef FRAME_RECEIVER_WITH_DEDUP_ACK_UNIT_MACROS_SVH
`define FRAME_RECEIVER_WITH_DEDUP_ACK_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FRX_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame receiver assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FRX_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame receiver assertion failed");

`endif

[src/frx_pkg.sv]
package frx_pkg;

    localparam int WIN_LEN        = 8;
    localparam int MAX_BURST_DEF  = 30;
    localparam int ZERO_RUN_LIMIT = 10;
    localparam int TOGGLE_POS     = 6;
    localparam int BYTE_W         = 8;
    localparam int MASK_W         = 6;
    localparam int PAYLOAD_W      = 24;
    localparam int CFG_IDX_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAD_FIRST  = 3'd0,
        CFG_HEAD_SECOND = 3'd1,
        CFG_TAIL_FIRST  = 3'd2,
        CFG_TAIL_SECOND = 3'd3,
        CFG_CHECK_MASK  = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        EV_REPEAT = 1'b0,
        EV_NEW    = 1'b1
    } t_event;

    typedef enum logic [1:0] {
        CLS_REJECT  = 2'd0,
        CLS_COMMAND = 2'd1,
        CLS_PACKED  = 2'd2,
        CLS_RAW     = 2'd3
    } t_class;

    typedef struct packed {
        logic [BYTE_W-1:0] head_first;
        logic [BYTE_W-1:0] head_second;
        logic [BYTE_W-1:0] tail_first;
        logic [BYTE_W-1:0] tail_second;
        logic [MASK_W-1:0] check_mask;
    } t_cfg;

    typedef logic [WIN_LEN-1:0][BYTE_W-1:0] t_window;

    typedef struct packed {
        logic    valid;
        logic    ge_win;
        logic    last;
        t_window window;
    } t_win_stage;

    typedef struct packed {
        t_event               event_code;
        logic [PAYLOAD_W-1:0] frame_payload;
        logic                 toggle_bit;
        t_class               packet_class;
        logic [BYTE_W-1:0]    field_one;
        logic [BYTE_W-1:0]    field_two;
        logic [BYTE_W-1:0]    field_three;
    } t_result;

    // True when no run of zero bits is longer than the limit.
    function automatic logic zero_run_ok(input logic [PAYLOAD_W-1:0] v);
        logic bad;
        bad = 1'b0;
        for (int i = 0; i <= PAYLOAD_W - ZERO_RUN_LIMIT - 1; i++) begin
            if (v[i +: ZERO_RUN_LIMIT + 1] == '0) begin
                bad = 1'b1;
            end
        end
        return !bad;
    endfunction

endpackage

[src/frx_in_if.sv]
interface frx_in_if import frx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              burst_end;

    modport source (output valid, output rx_byte, output burst_end, input ready);
    modport sink (input valid, input rx_byte, input burst_end, output ready);
endinterface

[src/frx_out_if.sv]
interface frx_out_if import frx_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 event_code;
    logic [PAYLOAD_W-1:0] frame_payload;
    logic                 toggle_bit;
    logic [1:0]           packet_class;
    logic [BYTE_W-1:0]    field_one;
    logic [BYTE_W-1:0]    field_two;
    logic [BYTE_W-1:0]    field_three;

    modport source (
        output valid, output event_code, output frame_payload, output toggle_bit,
        output packet_class, output field_one, output field_two, output field_three,
        input ready
    );
    modport sink (
        input valid, input event_code, input frame_payload, input toggle_bit,
        input packet_class, input field_one, input field_two, input field_three,
        output ready
    );
endinterface

[src/frx_window.sv]
module frx_window import frx_pkg::*; #(
    parameter int MAX_BURST = MAX_BURST_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    frx_in_if.sink      i_rx,
    input  logic        i_advance,
    output t_win_stage  o_stage
);
    localparam int CNT_W = $clog2(MAX_BURST + 1);

    logic              r_valid;
    logic              r_ge_win;
    logic              r_last;
    t_window           r_window;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt_inc;
    logic              accept;

    assign i_rx.ready = !r_valid || i_advance;
    assign accept     = i_rx.valid && i_rx.ready;
    assign n_cnt_inc  = r_cnt + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_cnt    <= '0;
            r_window <= '0;
            r_ge_win <= 1'b0;
            r_last   <= 1'b0;
        end else if (accept) begin
            r_valid  <= 1'b1;
            r_window <= {i_rx.rx_byte, r_window[WIN_LEN-1:1]};
            r_ge_win <= (n_cnt_inc >= CNT_W'(WIN_LEN));
            r_last   <= i_rx.burst_end || (n_cnt_inc >= CNT_W'(MAX_BURST));
            if (i_rx.burst_end || (n_cnt_inc >= CNT_W'(MAX_BURST))) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= n_cnt_inc;
            end
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    assign o_stage = '{valid: r_valid, ge_win: r_ge_win, last: r_last, window: r_window};
endmodule

[src/frx_decode.sv]
`include "frame_receiver_with_dedup_ack_unit_macros.svh"

module frx_decode import frx_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_win_stage i_stage,
    input  t_cfg       i_cfg,
    input  logic       i_out_free,
    output logic       o_advance,
    output logic       o_produce,
    output t_result    o_res
);
    logic                 r_taken;
    logic [PAYLOAD_W-1:0] r_last_payload;
    logic                 r_last_toggle;

    logic [BYTE_W-1:0]    b0, b1, b2, ck;
    logic [BYTE_W+1:0]    sum;
    logic [BYTE_W-1:0]    sum_lo;
    logic [2*BYTE_W-1:0]  sq;
    logic [MASK_W-1:0]    calc;
    logic                 frame_ok;
    logic                 match;
    logic                 repeat_hit;
    logic [PAYLOAD_W-1:0] payload;
    logic                 toggle;
    logic                 fire;

    assign b0      = i_stage.window[2];
    assign b1      = i_stage.window[3];
    assign b2      = i_stage.window[4];
    assign ck      = i_stage.window[5];
    assign sum     = {2'b00, b0} + {2'b00, b1} + {2'b00, b2};
    assign sum_lo  = sum[BYTE_W-1:0];
    assign sq      = sum_lo * sum_lo;
    assign calc    = ~sq[MASK_W-1:0] & i_cfg.check_mask;
    assign payload = {b0, b1, b2};
    assign toggle  = ck[TOGGLE_POS];

    assign frame_ok = i_stage.window[0] == i_cfg.head_first
                   && i_stage.window[1] == i_cfg.head_second
                   && i_stage.window[6] == i_cfg.tail_first
                   && i_stage.window[7] == i_cfg.tail_second
                   && (ck[MASK_W-1:0] & i_cfg.check_mask) == calc;

    assign match      = i_stage.valid && i_stage.ge_win && !r_taken && frame_ok;
    assign o_produce  = match && (payload != '0);
    assign repeat_hit = (payload == r_last_payload) && (toggle == r_last_toggle);
    assign o_advance  = !o_produce || i_out_free;
    assign fire       = i_stage.valid && o_advance;

    always_comb begin
        o_res = '{event_code: EV_NEW, frame_payload: payload, toggle_bit: toggle,
                  packet_class: CLS_REJECT, field_one: '0, field_two: '0,
                  field_three: '0};
        if (repeat_hit) begin
            o_res.event_code = EV_REPEAT;
        end else if (b0 == '0 && b1 == '0 && b2 != '0) begin
            o_res.packet_class = CLS_COMMAND;
            o_res.field_three  = b2;
        end else if (b1[3:0] == 4'h0 && b2 == '0) begin
            o_res.packet_class = CLS_PACKED;
            o_res.field_one    = {4'h0, b0[7:4]};
            o_res.field_two    = {4'h0, b0[3:0]};
            o_res.field_three  = {4'h0, b1[7:4]};
        end else if (zero_run_ok(payload)) begin
            o_res.packet_class = CLS_RAW;
            o_res.field_one    = b0;
            o_res.field_two    = b1;
            o_res.field_three  = b2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken        <= 1'b0;
            r_last_payload <= '0;
            r_last_toggle  <= 1'b0;
        end else if (fire) begin
            r_taken <= i_stage.last ? 1'b0 : (r_taken || match);
            if (o_produce && !repeat_hit) begin
                r_last_payload <= payload;
                r_last_toggle  <= toggle;
            end
        end
    end

    `FRX_ASSERT_SAME(a_taken_blocks, i_clk, i_rst_n, r_taken, !o_produce)
    `FRX_ASSERT_SAME(a_ack_silent, i_clk, i_rst_n, o_produce, payload != '0)
    `FRX_ASSERT_SAME(a_repeat_clean, i_clk, i_rst_n,
        o_produce && o_res.event_code == EV_REPEAT,
        o_res.packet_class == CLS_REJECT && o_res.field_one == '0
        && o_res.field_two == '0 && o_res.field_three == '0)
    `FRX_ASSERT_NEXT(a_new_stored, i_clk, i_rst_n,
        fire && o_produce && o_res.event_code == EV_NEW,
        r_last_payload == $past(payload) && r_last_toggle == $past(toggle))
endmodule

[src/frx_out_reg.sv]
module frx_out_reg import frx_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_result   i_res,
    output logic      o_free,
    frx_out_if.source o_res
);
    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.event_code    = r_res.event_code;
    assign o_res.frame_payload = r_res.frame_payload;
    assign o_res.toggle_bit    = r_res.toggle_bit;
    assign o_res.packet_class  = r_res.packet_class;
    assign o_res.field_one     = r_res.field_one;
    assign o_res.field_two     = r_res.field_two;
    assign o_res.field_three   = r_res.field_three;
endmodule

[src/frame_receiver_with_dedup_ack_unit.sv]
// Frame receiver: takes one received byte per transfer and slides an 8-byte window over each
// burst, which ends at a byte with burst_end set or at the MAX_BURST-th byte. The first window
// of a burst with matching head, tail and checksum is decoded; all-zero payloads are silent
// acknowledgements, a frame equal to the previous one gives a resend event, and any other frame
// is stored, classified and reported. A byte can be accepted every cycle unless the input
// stalls. Each byte is registered in the window register and is decoded combinationally
// into the output register, which offers the result. When a new result is ready while the
// output register still holds one that has not been taken, the input stalls until the output
// transfer happens. Configuration is written through the plain write port.
module frame_receiver_with_dedup_ack_unit import frx_pkg::*; #(
    parameter int MAX_BURST = MAX_BURST_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    frx_in_if.sink               i_rx,
    frx_out_if.source            o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data
);
    t_cfg       r_cfg;
    t_win_stage stage;
    t_result    res;
    logic       advance;
    logic       produce;
    logic       out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{head_first: 8'd252, head_second: 8'd251, tail_first: 8'd253,
                       tail_second: 8'd254, check_mask: 6'd63};
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HEAD_FIRST:  r_cfg.head_first  <= i_cfg_data;
                CFG_HEAD_SECOND: r_cfg.head_second <= i_cfg_data;
                CFG_TAIL_FIRST:  r_cfg.tail_first  <= i_cfg_data;
                CFG_TAIL_SECOND: r_cfg.tail_second <= i_cfg_data;
                CFG_CHECK_MASK:  r_cfg.check_mask  <= i_cfg_data[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    frx_window #(.MAX_BURST(MAX_BURST)) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_advance (advance),
        .o_stage   (stage)
    );

    frx_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stage    (stage),
        .i_cfg      (r_cfg),
        .i_out_free (out_free),
        .o_advance  (advance),
        .o_produce  (produce),
        .o_res      (res)
    );

    frx_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (produce && out_free),
        .i_res   (res),
        .o_free  (out_free),
        .o_res   (o_res)
    );
endmodule
